// ===== sv/bmxh_pkg.sv =====
// Package for the block multiply-xor hash.
// Holds the block record handed from the byte gatherer to the hashing pipeline.
`timescale 1ns / 1ps

package bmxh_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned QueueDepth = 2;

  // One gathered block, ready to be folded into the accumulator.
  typedef struct packed {
    logic [63:0] t;       // bytes 0..7, little-endian
    logic [31:0] s;       // bytes 8..11 xor bytes 12..15
    logic [63:0] offset;  // byte index where the block starts
    logic [63:0] count;   // bytes seen so far, including this block
    logic        last;    // block closes the message
  } blk_t;

endpackage

// ===== sv/bmxh_front.sv =====
// Byte gatherer: assembles message bytes into zero-padded 16-byte blocks.
// Depends on bmxh_pkg for the block record.
`timescale 1ns / 1ps

module bmxh_front import bmxh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_data_i,
  input  logic       in_last_i,
  input  logic       space_i,
  output logic       push_o,
  output blk_t       blk_o
);

  logic [15:0][7:0] buf_q, buf_next;
  logic [3:0]       pos_q;
  logic [63:0]      count_q;
  logic [63:0]      start_q;
  logic             accept;
  logic             done;

  assign in_ready_o = space_i;
  assign accept     = in_valid_i && space_i;
  assign done       = (pos_q == 4'hF) || in_last_i;

  always_comb begin
    buf_next        = buf_q;
    buf_next[pos_q] = in_data_i;
  end

  assign push_o        = accept && done;
  assign blk_o.t       = buf_next[7:0];
  assign blk_o.s       = buf_next[11:8] ^ buf_next[15:12];
  assign blk_o.offset  = start_q;
  assign blk_o.count   = count_q + 64'd1;
  assign blk_o.last    = in_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q   <= '0;
      pos_q   <= '0;
      count_q <= '0;
      start_q <= '0;
    end else if (accept) begin
      // The buffer is cleared after every block so a short final block reads zero-padded.
      buf_q <= done ? '0 : buf_next;
      if (in_last_i) begin
        pos_q   <= '0;
        count_q <= '0;
        start_q <= '0;
      end else begin
        pos_q   <= pos_q + 4'd1;
        count_q <= count_q + 64'd1;
        if (pos_q == 4'hF) begin
          start_q <= count_q + 64'd1;
        end
      end
    end
  end

endmodule

// ===== sv/bmxh_fifo.sv =====
// Two-entry queue of block records between the gatherer and the hash pipeline.
// Depends on bmxh_pkg for the block record and the depth.
`timescale 1ns / 1ps

module bmxh_fifo import bmxh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  blk_t push_data_i,
  output logic space_o,
  output logic valid_o,
  input  logic pop_i,
  output blk_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  blk_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign space_o    = (cnt_q != CntW'(QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== sv/bmxh_back.sv =====
// Hash pipeline: forms the two 64-bit products of a block from 32-bit partial
// products, folds them into the accumulator and registers the checksum.
// Depends on bmxh_pkg for the block record.
`timescale 1ns / 1ps

module bmxh_back import bmxh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  blk_t        blk_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_data_o
);

  logic        en;
  logic [63:0] s_ext;

  // Stage 1: operands.
  logic        v1_q;
  logic [63:0] a_op_q, a_m_q, b_op_q, b_m_q;
  logic [63:0] cnt1_q;
  logic        last1_q;

  // Stage 2: partial products.
  logic        v2_q;
  logic [63:0] a_ll_q, b_ll_q;
  logic [31:0] a_lh_q, a_hl_q, b_lh_q, b_hl_q;
  logic [63:0] cnt2_q;
  logic        last2_q;

  // Stage 3: fold value.
  logic        v3_q;
  logic [63:0] fold3_q;
  logic [63:0] cnt3_q;
  logic        last3_q;
  logic [31:0] a_cross, b_cross;
  logic [63:0] a_prod, b_prod;

  logic [63:0] acc_q;
  logic        out_valid_q;
  logic [63:0] out_data_q;

  // The whole pipeline holds while a checksum waits to be taken.
  assign en    = !(out_valid_q && !out_ready_i);
  assign pop_o = en && valid_i;
  assign s_ext = {{32{blk_i.s[31]}}, blk_i.s};

  assign a_cross = a_lh_q + a_hl_q;
  assign b_cross = b_lh_q + b_hl_q;
  assign a_prod  = a_ll_q + {a_cross, 32'd0};
  assign b_prod  = b_ll_q + {b_cross, 32'd0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_op_q  <= ~blk_i.t;
      a_m_q   <= s_ext;
      b_op_q  <= blk_i.t + blk_i.offset;
      b_m_q   <= ~s_ext;
      cnt1_q  <= blk_i.count;
      last1_q <= blk_i.last;

      a_ll_q  <= 64'(a_op_q[31:0] * a_m_q[31:0]);
      a_lh_q  <= 32'(a_op_q[31:0] * a_m_q[63:32]);
      a_hl_q  <= 32'(a_op_q[63:32] * a_m_q[31:0]);
      b_ll_q  <= 64'(b_op_q[31:0] * b_m_q[31:0]);
      b_lh_q  <= 32'(b_op_q[31:0] * b_m_q[63:32]);
      b_hl_q  <= 32'(b_op_q[63:32] * b_m_q[31:0]);
      cnt2_q  <= cnt1_q;
      last2_q <= last1_q;

      fold3_q <= a_prod ^ b_prod;
      cnt3_q  <= cnt2_q;
      last3_q <= last2_q;
    end
    if (en && v3_q && last3_q) begin
      out_data_q <= acc_q ^ fold3_q ^ cnt3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q && last3_q;
      if (v3_q) begin
        acc_q <= last3_q ? '0 : (acc_q ^ fold3_q);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/block_multiply_xor_hash64_top.sv =====
// Top level of the block multiply-xor hash: gatherer, block queue, hash pipeline.
// Depends on bmxh_pkg, bmxh_front, bmxh_fifo and bmxh_back.
//
//   Channel  Dir  Payload                          Transaction
//   s_axis   in   tdata[7:0] data_byte, tlast      one message byte
//   m_axis   out  tdata[63:0] checksum            one hash per message
//
// Message bytes are taken at one per cycle while the block queue has space.
// After the edge that accepts the last byte of a message, its block passes the block queue,
// the operand, partial-product and fold stages and the checksum register, when nothing stalls.
// The 64-bit products are built from 32-bit partial products over a three-stage
// pipeline; blocks can leave the gatherer in consecutive cycles.
// Reset clears the gathered block, the byte count and the accumulator.
// While a checksum is not taken the pipeline holds, the two-entry block queue
// fills and then s_axis_tready_o drops.
`timescale 1ns / 1ps

module block_multiply_xor_hash64_top import bmxh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o    // [63:0] checksum, two's complement
);

  logic fifo_push, fifo_space, fifo_valid, fifo_pop;
  blk_t push_blk, pop_blk;

  bmxh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .space_i    (fifo_space),
    .push_o     (fifo_push),
    .blk_o      (push_blk)
  );

  bmxh_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (push_blk),
    .space_o     (fifo_space),
    .valid_o     (fifo_valid),
    .pop_i       (fifo_pop),
    .pop_data_o  (pop_blk)
  );

  bmxh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (fifo_valid),
    .blk_i       (pop_blk),
    .pop_o       (fifo_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  // A block is never pushed into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(fifo_push && !fifo_space))
    else $error("block pushed into full queue");

  // A stalled checksum freezes the pipeline, so no block leaves the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !fifo_pop)
    else $error("queue popped while output stalled");

  // A block cannot be popped from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fifo_pop |-> fifo_valid)
    else $error("pop from empty queue");

endmodule
